FILE: rtl/absc_pkg.sv
// absc_pkg: shared types, byte codes, position table and control-store ROM
// for the antenna beam select controller. No dependencies.
`default_nettype none

package absc_pkg;

  localparam int MAX_POS = 6;

  localparam logic [7:0] BYTE_TRIG   = 8'hFF;
  localparam logic [7:0] BYTE_SCAN   = 8'h4E;
  localparam logic [7:0] BYTE_SEL    = 8'h73;
  localparam logic [7:0] BYTE_SIG    = 8'h52;
  localparam logic [7:0] BYTE_QUAL   = 8'h4C;
  localparam logic [7:0] BYTE_REPORT = 8'h53;

  localparam logic [3:0] STATE_DEFAULT = 4'd5;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [3:0] switch_state;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       save_valid;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    PH_WAIT_TRIG,
    PH_WAIT_CMD,
    PH_WAIT_SEL,
    PH_WAIT_R,
    PH_GET_SIG,
    PH_WAIT_L,
    PH_GET_QUAL
  } phase_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DECODE,
    OP_MM_INIT,
    OP_MM_STEP,
    OP_PICK_INIT,
    OP_PICK_STEP,
    OP_APPLY
  } op_t;

  typedef enum logic [1:0] {
    J_NONE,
    J_SCAN_END,
    J_IDX_MORE,
    J_PICK_MORE
  } cond_t;

  typedef enum logic [1:0] {
    TX_NONE,
    TX_REPORT,
    TX_STATE
  } tx_t;

  typedef enum logic [1:0] {
    SV_NONE,
    SV_FLAG,
    SV_ONE
  } sv_t;

  typedef struct packed {
    op_t        op;
    cond_t      cond;
    logic [3:0] target;
    logic       emit;
    tx_t        tx;
    sv_t        save;
    logic       last;
    logic       done;
  } ucw_t;

  localparam logic [3:0] STEP_DECODE  = 4'd0;
  localparam logic [3:0] STEP_PLAIN   = 4'd1;
  localparam logic [3:0] STEP_MM_INIT = 4'd2;
  localparam logic [3:0] STEP_MM      = 4'd3;
  localparam logic [3:0] STEP_PK_INIT = 4'd4;
  localparam logic [3:0] STEP_PK      = 4'd5;
  localparam logic [3:0] STEP_APPLY   = 4'd6;
  localparam logic [3:0] STEP_TX_S    = 4'd7;
  localparam logic [3:0] STEP_TX_ST   = 4'd8;

  function automatic logic [3:0] pos_state(input logic [2:0] pos);
    logic [3:0] s;
    case (pos)
      3'd0:    s = 4'd5;
      3'd1:    s = 4'd4;
      3'd2:    s = 4'd6;
      3'd3:    s = 4'd2;
      3'd4:    s = 4'd8;
      3'd5:    s = 4'd3;
      default: s = 4'd5;
    endcase
    return s;
  endfunction

  function automatic ucw_t ucode(input logic [3:0] step);
    ucw_t w;
    w = '{op: OP_NOP, cond: J_NONE, target: STEP_DECODE, emit: 1'b0, tx: TX_NONE,
          save: SV_NONE, last: 1'b0, done: 1'b0};
    unique case (step)
      STEP_DECODE: begin
        w.op     = OP_DECODE;
        w.cond   = J_SCAN_END;
        w.target = STEP_MM_INIT;
      end
      STEP_PLAIN: begin
        w.emit = 1'b1;
        w.save = SV_FLAG;
        w.last = 1'b1;
        w.done = 1'b1;
      end
      STEP_MM_INIT: w.op = OP_MM_INIT;
      STEP_MM: begin
        w.op     = OP_MM_STEP;
        w.cond   = J_IDX_MORE;
        w.target = STEP_MM;
      end
      STEP_PK_INIT: w.op = OP_PICK_INIT;
      STEP_PK: begin
        w.op     = OP_PICK_STEP;
        w.cond   = J_PICK_MORE;
        w.target = STEP_PK;
      end
      STEP_APPLY: w.op = OP_APPLY;
      STEP_TX_S: begin
        w.emit = 1'b1;
        w.tx   = TX_REPORT;
      end
      STEP_TX_ST: begin
        w.emit = 1'b1;
        w.tx   = TX_STATE;
        w.save = SV_ONE;
        w.last = 1'b1;
        w.done = 1'b1;
      end
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/antenna_beam_select_controller_top.sv
// antenna_beam_select_controller_top: microcoded controller for the antenna switch.
// Depends on absc_pkg (types, byte codes, position table, control-store ROM).
// Sequence: an ordinary word runs the decode step, then a step that emits its result;
// busy drops when that step ends, so a new word is taken only after the last is done. A scan-closing word runs the
// min/max and pick loops over SCAN_POSITIONS entries, applies the pick and emits two words.
// Sync reset: idle, waiting for trigger, scan position 0, switch state 5.
`default_nettype none

module antenna_beam_select_controller_top #(
  parameter int SCAN_POSITIONS = 6
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  absc_pkg::item_t        item,
  output logic                   strobe,
  output absc_pkg::result_t      result
);

  localparam int NPOS = (SCAN_POSITIONS < 1) ? 1 :
                        (SCAN_POSITIONS > absc_pkg::MAX_POS) ? absc_pkg::MAX_POS :
                        SCAN_POSITIONS;
  localparam logic [2:0] LAST_POS = 3'(NPOS - 1);

  logic              run;
  logic [3:0]        step;
  logic [3:0]        step_next;
  logic              cmd_q;
  logic [7:0]        byte_q;
  absc_pkg::phase_t  phase;
  logic [2:0]        scan_pos;
  logic [7:0]        sig_mem  [absc_pkg::MAX_POS];
  logic [7:0]        qual_mem [absc_pkg::MAX_POS];
  logic [7:0]        smin;
  logic [7:0]        qmax;
  logic [2:0]        idx;
  logic [2:0]        sel;
  logic              found;
  logic              save_flag;
  logic [3:0]        current_state;

  absc_pkg::ucw_t    uop;
  logic              accept;
  logic              take;
  logic              scan_end;
  logic [7:0]        rd_sig;
  logic [7:0]        rd_qual;
  logic              eq_sig;
  logic              hit;
  logic              byte_in_range;

  assign uop           = absc_pkg::ucode(step);
  assign accept        = start & ~run;
  assign busy          = run;
  assign rd_sig        = sig_mem[idx];
  assign rd_qual       = qual_mem[idx];
  assign eq_sig        = (rd_sig == smin);
  assign hit           = eq_sig & (rd_qual == qmax);
  assign scan_end      = ~cmd_q & (phase == absc_pkg::PH_GET_QUAL) & (scan_pos == LAST_POS);
  assign byte_in_range = (byte_q >= 8'd1) && (byte_q <= 8'd9);

  always_comb begin
    case (uop.cond)
      absc_pkg::J_SCAN_END:  take = scan_end;
      absc_pkg::J_IDX_MORE:  take = (idx != LAST_POS);
      absc_pkg::J_PICK_MORE: take = ~hit & (idx != LAST_POS);
      default:               take = 1'b0;
    endcase
    step_next = take ? uop.target : step + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run           <= 1'b0;
      step          <= absc_pkg::STEP_DECODE;
      phase         <= absc_pkg::PH_WAIT_TRIG;
      scan_pos      <= 3'd0;
      current_state <= absc_pkg::STATE_DEFAULT;
      save_flag     <= 1'b0;
    end else if (accept) begin
      run    <= 1'b1;
      step   <= absc_pkg::STEP_DECODE;
      cmd_q  <= item.command;
      byte_q <= item.data_byte;
    end else if (run) begin
      step <= step_next;
      if (uop.done) begin
        run <= 1'b0;
      end
      case (uop.op)
        absc_pkg::OP_DECODE: begin
          save_flag <= ~cmd_q & (phase == absc_pkg::PH_WAIT_SEL) & byte_in_range;
          if (cmd_q) begin
            current_state <= byte_in_range ? byte_q[3:0] : absc_pkg::STATE_DEFAULT;
          end else begin
            case (phase)
              absc_pkg::PH_WAIT_CMD: begin
                if (byte_q == absc_pkg::BYTE_SCAN) begin
                  scan_pos      <= 3'd0;
                  current_state <= absc_pkg::pos_state(3'd0);
                  phase         <= absc_pkg::PH_WAIT_R;
                end else if (byte_q == absc_pkg::BYTE_SEL) begin
                  phase <= absc_pkg::PH_WAIT_SEL;
                end
              end
              absc_pkg::PH_WAIT_SEL: begin
                if (byte_in_range) begin
                  current_state <= byte_q[3:0];
                  phase         <= absc_pkg::PH_WAIT_TRIG;
                end
              end
              absc_pkg::PH_WAIT_R: begin
                if (byte_q == absc_pkg::BYTE_SIG) phase <= absc_pkg::PH_GET_SIG;
              end
              absc_pkg::PH_GET_SIG: begin
                sig_mem[scan_pos] <= byte_q;
                phase             <= absc_pkg::PH_WAIT_L;
              end
              absc_pkg::PH_WAIT_L: begin
                if (byte_q == absc_pkg::BYTE_QUAL) phase <= absc_pkg::PH_GET_QUAL;
              end
              absc_pkg::PH_GET_QUAL: begin
                qual_mem[scan_pos] <= byte_q;
                if (scan_pos != LAST_POS) begin
                  scan_pos      <= scan_pos + 3'd1;
                  current_state <= absc_pkg::pos_state(scan_pos + 3'd1);
                  phase         <= absc_pkg::PH_WAIT_R;
                end
              end
              default: begin
                phase <= (byte_q == absc_pkg::BYTE_TRIG) ? absc_pkg::PH_WAIT_CMD
                                                          : absc_pkg::PH_WAIT_TRIG;
              end
            endcase
          end
        end
        absc_pkg::OP_MM_INIT: begin
          idx  <= 3'd0;
          smin <= 8'hFF;
          qmax <= 8'h00;
        end
        absc_pkg::OP_MM_STEP: begin
          if (rd_sig < smin) smin <= rd_sig;
          if (rd_qual > qmax) qmax <= rd_qual;
          idx <= idx + 3'd1;
        end
        absc_pkg::OP_PICK_INIT: begin
          idx   <= 3'd0;
          found <= 1'b0;
        end
        absc_pkg::OP_PICK_STEP: begin
          if (eq_sig && (!found || hit)) sel <= idx;
          if (eq_sig) found <= 1'b1;
          idx <= idx + 3'd1;
        end
        absc_pkg::OP_APPLY: begin
          current_state <= absc_pkg::pos_state(sel);
          scan_pos      <= 3'd0;
          phase         <= absc_pkg::PH_WAIT_TRIG;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    strobe              = run & uop.emit;
    result.switch_state = current_state;
    result.last         = uop.last;
    case (uop.tx)
      absc_pkg::TX_REPORT: begin
        result.tx_valid = 1'b1;
        result.tx_byte  = absc_pkg::BYTE_REPORT;
      end
      absc_pkg::TX_STATE: begin
        result.tx_valid = 1'b1;
        result.tx_byte  = {4'd0, current_state};
      end
      default: begin
        result.tx_valid = 1'b0;
        result.tx_byte  = 8'd0;
      end
    endcase
    case (uop.save)
      absc_pkg::SV_FLAG: result.save_valid = save_flag;
      absc_pkg::SV_ONE:  result.save_valid = 1'b1;
      default:           result.save_valid = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: test/antenna_beam_select_controller_top_test.sv
// Self-checking testbench for antenna_beam_select_controller_top: drives serial and
// restore words, predicts each result word and compares them in order.
// Depends on absc_pkg and the RTL top level only.

class beam_tracker;
  absc_pkg::phase_t  phase;
  int                positions;
  int                position;
  logic [7:0]        signal_level[6];
  logic [7:0]        link_quality[6];
  logic [3:0]        applied;
  logic [3:0]        scan_states[6];
  absc_pkg::result_t due_words[$];
  int                mismatches;

  function new(int n);
    positions   = n;
    phase       = absc_pkg::PH_WAIT_TRIG;
    position    = 0;
    applied     = absc_pkg::STATE_DEFAULT;
    scan_states = '{4'd5, 4'd4, 4'd6, 4'd2, 4'd8, 4'd3};
    mismatches  = 0;
  endfunction

  function int pending();
    return due_words.size();
  endfunction

  // lowest min-signal position with max quality, else lowest min-signal position
  function int best_position();
    logic [7:0] smin;
    logic [7:0] qmax;
    int         first;
    smin  = signal_level[0];
    qmax  = link_quality[0];
    first = -1;
    for (int i = 1; i < positions; i++) begin
      if (signal_level[i] < smin) smin = signal_level[i];
      if (link_quality[i] > qmax) qmax = link_quality[i];
    end
    for (int i = 0; i < positions; i++) begin
      if (signal_level[i] == smin) begin
        if (first < 0) first = i;
        if (link_quality[i] == qmax) return i;
      end
    end
    return (first < 0) ? 0 : first;
  endfunction

  function void take_byte(absc_pkg::item_t w);
    absc_pkg::result_t r;
    logic [7:0]        b;
    logic              saved;
    b     = w.data_byte;
    r     = '0;
    saved = 1'b0;
    if (w.command) begin
      applied = (b >= 8'd1 && b <= 8'd9) ? b[3:0] : absc_pkg::STATE_DEFAULT;
    end else begin
      case (phase)
        absc_pkg::PH_WAIT_CMD: begin
          if (b == absc_pkg::BYTE_SCAN) begin
            position = 0;
            applied  = scan_states[0];
            phase    = absc_pkg::PH_WAIT_R;
          end else if (b == absc_pkg::BYTE_SEL) begin
            phase = absc_pkg::PH_WAIT_SEL;
          end
        end
        absc_pkg::PH_WAIT_SEL: begin
          if (b >= 8'd1 && b <= 8'd9) begin
            applied = b[3:0];
            saved   = 1'b1;
            phase   = absc_pkg::PH_WAIT_TRIG;
          end
        end
        absc_pkg::PH_WAIT_R: begin
          if (b == absc_pkg::BYTE_SIG) phase = absc_pkg::PH_GET_SIG;
        end
        absc_pkg::PH_GET_SIG: begin
          signal_level[position] = b;
          phase = absc_pkg::PH_WAIT_L;
        end
        absc_pkg::PH_WAIT_L: begin
          if (b == absc_pkg::BYTE_QUAL) phase = absc_pkg::PH_GET_QUAL;
        end
        absc_pkg::PH_GET_QUAL: begin
          link_quality[position] = b;
          if (position + 1 < positions) begin
            position = position + 1;
            applied  = scan_states[position];
            phase    = absc_pkg::PH_WAIT_R;
          end else begin
            applied        = scan_states[best_position()];
            position       = 0;
            phase          = absc_pkg::PH_WAIT_TRIG;
            r.switch_state = applied;
            r.tx_valid     = 1'b1;
            r.tx_byte      = absc_pkg::BYTE_REPORT;
            due_words.push_back(r);
            r.tx_byte      = {4'd0, applied};
            r.save_valid   = 1'b1;
            r.last         = 1'b1;
            due_words.push_back(r);
            return;
          end
        end
        default: begin
          phase = (b == absc_pkg::BYTE_TRIG) ? absc_pkg::PH_WAIT_CMD : absc_pkg::PH_WAIT_TRIG;
        end
      endcase
    end
    r.switch_state = applied;
    r.save_valid   = saved;
    r.last         = 1'b1;
    due_words.push_back(r);
  endfunction

  function void compare(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function void match_word(absc_pkg::result_t got);
    absc_pkg::result_t want;
    if (due_words.size() == 0) begin
      $error("result word with none expected: %h", got);
      mismatches++;
      return;
    end
    want = due_words.pop_front();
    compare("switch_state", 32'(want.switch_state), 32'(got.switch_state));
    compare("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
    compare("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
    compare("save_valid", 32'(want.save_valid), 32'(got.save_valid));
    compare("last", 32'(want.last), 32'(got.last));
  endfunction
endclass

module antenna_beam_select_controller_top_test;
  import absc_pkg::*;

  localparam int POSITIONS = 6;
  localparam int WATCHDOG  = 2000;
  localparam int ITEMS     = 1450;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        strobe;
  result_t     result;

  beam_tracker tracker;
  int          idle_cycles;
  int          words_sent;

  antenna_beam_select_controller_top #(.SCAN_POSITIONS(POSITIONS)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (strobe) tracker.match_word(result);
      if (start && !busy) tracker.take_byte(item);
      if (strobe || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly tight ranges so that signal and quality ties are common
  function automatic logic [7:0] probe_value();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(10, 12));
    endcase
  endfunction

  function automatic logic [7:0] restore_value();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(1, 9));
    return $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(10, 255));
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic push_word(input logic cmd, input logic [7:0] b, input bit steady,
                           input bit tally);
    item_t w;
    int    gap;
    w.command   = cmd;
    w.data_byte = b;
    item  <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (tally) words_sent++;
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
  endtask

  task automatic send_burst(input logic [7:0] burst[$], input bit tally);
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    foreach (burst[i]) begin
      if ($urandom_range(0, 29) == 0) push_word(1'b1, restore_value(), steady, 1'b1);
      push_word(1'b0, burst[i], steady, tally);
    end
  endtask

  task automatic build_scan(output logic [7:0] burst[$]);
    burst = {BYTE_TRIG, BYTE_SCAN};
    for (int p = 0; p < POSITIONS; p++) begin
      if ($urandom_range(0, 5) == 0) burst.push_back(8'($urandom_range(0, 255)));
      burst.push_back(BYTE_SIG);
      burst.push_back(probe_value());
      if ($urandom_range(0, 5) == 0) burst.push_back(8'($urandom_range(0, 255)));
      burst.push_back(BYTE_QUAL);
      burst.push_back(probe_value());
    end
  endtask

  initial begin
    logic [7:0] burst[$];
    logic [7:0] opening[$];
    int         kind;
    tracker     = new(POSITIONS);
    words_sent  = 0;
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // restores at the range edges and out of range
    push_word(1'b1, 8'd0, 1'b0, 1'b1);
    push_word(1'b1, 8'd1, 1'b0, 1'b1);
    push_word(1'b1, 8'd9, 1'b0, 1'b1);
    push_word(1'b1, 8'd10, 1'b0, 1'b1);
    push_word(1'b1, 8'hFF, 1'b0, 1'b1);
    // stray byte, repeated trigger, unknown command, then manual selects
    opening = {8'h00, BYTE_TRIG, BYTE_TRIG, 8'h41,
               BYTE_TRIG, BYTE_SEL, 8'h00, 8'h0A, 8'hFF, 8'd9,
               BYTE_TRIG, BYTE_SEL, 8'd1};
    foreach (opening[i]) push_word(1'b0, opening[i], 1'b0, 1'b1);
    drain();

    while (words_sent < ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        build_scan(burst);
        send_burst(burst, 1'b1);
      end else if (kind < 75) begin
        burst = {BYTE_TRIG, BYTE_SEL};
        if ($urandom_range(0, 2) == 0) begin
          burst.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(10, 255)));
        end
        burst.push_back(8'($urandom_range(1, 9)));
        send_burst(burst, 1'b1);
      end else if (kind < 87) begin
        burst = {};
        repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(0, 255)));
        send_burst(burst, 1'b0);
      end else begin
        build_scan(burst);
        burst = burst[0:$urandom_range(1, burst.size() - 2)];
        send_burst(burst, 1'b1);
      end
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (2 * POSITIONS + 8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: antenna_beam_select_controller_top.f
rtl/absc_pkg.sv
rtl/antenna_beam_select_controller_top.sv
test/antenna_beam_select_controller_top_test.sv
